/* rtl/stw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stw_pkg
// Shared sizes, codes and types of the sorted timestamp window.
// ----------------------------------------------------------------------------
package stw_pkg;

    // window storage
    localparam int DEPTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // field widths
    localparam int TIME_W = 32;
    localparam int PAY_W  = 64;
    localparam int CFG_W  = 6;
    localparam int OUT_W  = 6;

    // width that holds both a count and the limit register
    localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(30);

    typedef enum logic [1:0] {
        ACT_REPLACE = 2'd0,
        ACT_INSERT  = 2'd1,
        ACT_EVICT   = 2'd2,
        ACT_DROP    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_EV_RD,
        ST_EV_LAT,
        ST_SH_RD,
        ST_SH_WR,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
    } t_ram_ctrl;

    typedef struct packed {
        t_action           action;
        logic [OUT_W-1:0]  slot;
        logic [OUT_W-1:0]  fill_count;
        logic [TIME_W-1:0] evicted_time;
    } t_result;

endpackage

/* rtl/sorted_timestamp_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timestamp_window
// Bounded list of records kept sorted by timestamp, newest first.
// ----------------------------------------------------------------------------
// One word is handled at a time. The scan reads one stored entry per pass
// through a registered RAM read into one compare unit. Entries are then
// shifted down one at a time, after the evicted timestamp is read when the
// window is full. The scan stops at the insert position, and the shift runs
// from the end of the list down to that position. The result word sits in
// an output register, so the next input word is taken while a result waits.
// max_entries is written through i_cfg_we/i_cfg_data; the user must write
// it only while idle, the block itself does not enforce this. Values above
// the storage depth act as the depth.
// ----------------------------------------------------------------------------
module sorted_timestamp_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [stw_pkg::TIME_W-1:0] i_record_time,
    input  logic [stw_pkg::PAY_W-1:0]  i_record_payload,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_action,
    output logic [stw_pkg::OUT_W-1:0]  o_slot,
    output logic [stw_pkg::OUT_W-1:0]  o_fill_count,
    output logic [stw_pkg::TIME_W-1:0] o_evicted_time,
    input  logic                       i_cfg_we,
    input  logic [stw_pkg::CFG_W-1:0]  i_cfg_data
);

    import stw_pkg::*;

    t_ram_ctrl         w_ram;
    logic [TIME_W-1:0] w_wr_time;
    logic [PAY_W-1:0]  w_wr_payload;
    logic [TIME_W-1:0] w_rd_time;
    logic [PAY_W-1:0]  w_rd_payload;
    logic              w_res_load;
    logic              w_res_free;
    t_result           w_res;
    logic              r_out_valid;
    t_result           r_out;

    // sequencer with the shared compare unit
    stw_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_record_time    (i_record_time),
        .i_record_payload (i_record_payload),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_rd_time        (w_rd_time),
        .i_rd_payload     (w_rd_payload),
        .o_ram            (w_ram),
        .o_wr_time        (w_wr_time),
        .o_wr_payload     (w_wr_payload),
        .i_res_free       (w_res_free),
        .o_res_load       (w_res_load),
        .o_res            (w_res)
    );

    // timestamp store
    stw_ram #(
        .WIDTH (TIME_W),
        .DEPTH (DEPTH)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_wr_time),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rd_time)
    );

    // payload store
    stw_ram #(
        .WIDTH (PAY_W),
        .DEPTH (DEPTH)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_wr_payload),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rd_payload)
    );

    // output register
    assign w_res_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) r_out <= w_res;
    end

    assign o_valid        = r_out_valid;
    assign o_action       = r_out.action;
    assign o_slot         = r_out.slot;
    assign o_fill_count   = r_out.fill_count;
    assign o_evicted_time = r_out.evicted_time;

endmodule

/* rtl/stw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stw_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module stw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/stw_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stw_seq
// Sequencer of the window: scans with one shared comparator, shifts entries
// one at a time for an insert or eviction, and writes a kept word into place.
// ----------------------------------------------------------------------------
module stw_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [stw_pkg::TIME_W-1:0] i_record_time,
    input  logic [stw_pkg::PAY_W-1:0]  i_record_payload,
    input  logic                       i_cfg_we,
    input  logic [stw_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [stw_pkg::TIME_W-1:0] i_rd_time,
    input  logic [stw_pkg::PAY_W-1:0]  i_rd_payload,
    output stw_pkg::t_ram_ctrl         o_ram,
    output logic [stw_pkg::TIME_W-1:0] o_wr_time,
    output logic [stw_pkg::PAY_W-1:0]  o_wr_payload,
    input  logic                       i_res_free,
    output logic                       o_res_load,
    output stw_pkg::t_result           o_res
);

    import stw_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [CFG_W-1:0]   r_max;
    logic [CNT_W-1:0]   r_held;
    logic [TIME_W-1:0]  r_time;
    logic [PAY_W-1:0]   r_pay;
    logic [LIM_W-1:0]   r_lim;
    logic [LIM_W-1:0]   r_n;
    logic [LIM_W-1:0]   r_idx;
    logic [LIM_W-1:0]   r_pos;
    logic [LIM_W-1:0]   r_slot;
    t_action            r_act;
    logic [TIME_W-1:0]  r_ev;

    logic [LIM_W-1:0]   w_lim;
    logic [LIM_W-1:0]   w_held;
    logic [LIM_W-1:0]   w_n;
    logic [LIM_W-1:0]   w_idx_dec;
    logic [LIM_W-1:0]   w_last;
    logic               w_eq;
    logic               w_lt;

    // effective limit and present count at the start of an item
    assign w_held    = LIM_W'(r_held);
    assign w_lim     = (LIM_W'(r_max) < LIM_W'(DEPTH)) ? LIM_W'(r_max) : LIM_W'(DEPTH);
    assign w_n       = (w_held < w_lim) ? w_held : w_lim;
    assign w_idx_dec = r_idx - LIM_W'(1);
    assign w_last    = r_n - LIM_W'(1);

    // shared comparator against the stored timestamp just read
    assign w_eq = (i_rd_time == r_time);
    assign w_lt = (i_rd_time <  r_time);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                n_state = (r_idx == r_n) ? ST_DECIDE : ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (w_eq)      n_state = ST_WRITE;
                else if (w_lt) n_state = ST_DECIDE;
                else           n_state = ST_SCAN_RD;
            end
            ST_DECIDE: begin
                if (r_n < r_lim)       n_state = ST_SH_RD;
                else if (r_pos >= r_n) n_state = ST_DONE;
                else                   n_state = ST_EV_RD;
            end
            ST_EV_RD:  n_state = ST_EV_LAT;
            ST_EV_LAT: n_state = ST_SH_RD;
            ST_SH_RD: begin
                n_state = (r_idx == r_pos) ? ST_WRITE : ST_SH_WR;
            end
            ST_SH_WR:  n_state = ST_SH_RD;
            ST_WRITE:  n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs: handshake and memory control
    always_comb begin
        o_ready      = 1'b0;
        o_res_load   = 1'b0;
        o_ram.we     = 1'b0;
        o_ram.waddr  = r_idx[IDX_W-1:0];
        o_ram.raddr  = r_idx[IDX_W-1:0];
        o_wr_time    = i_rd_time;
        o_wr_payload = i_rd_payload;
        case (r_state)
            ST_IDLE:    o_ready = 1'b1;
            ST_EV_RD:   o_ram.raddr = w_last[IDX_W-1:0];
            ST_SH_RD:   o_ram.raddr = w_idx_dec[IDX_W-1:0];
            ST_SH_WR:   o_ram.we = 1'b1;
            ST_WRITE: begin
                o_ram.we     = 1'b1;
                o_ram.waddr  = r_pos[IDX_W-1:0];
                o_wr_time    = r_time;
                o_wr_payload = r_pay;
            end
            ST_DONE:    o_res_load = i_res_free;
            default:    o_ready = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_max   <= MAX_ENTRIES_RST;
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_max <= i_cfg_data;
            if (r_state == ST_DONE && i_res_free) r_held <= r_n[CNT_W-1:0];
        end
    end

    // working registers of the current word
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_time <= i_record_time;
                    r_pay  <= i_record_payload;
                    r_lim  <= w_lim;
                    r_n    <= w_n;
                    r_idx  <= '0;
                    r_ev   <= '0;
                end
            end
            ST_SCAN_RD: begin
                if (r_idx == r_n) r_pos <= r_n;
            end
            ST_SCAN_CMP: begin
                if (w_eq) begin
                    r_pos  <= r_idx;
                    r_slot <= r_idx;
                    r_act  <= ACT_REPLACE;
                end else if (w_lt) begin
                    r_pos  <= r_idx;
                end else begin
                    r_idx  <= r_idx + LIM_W'(1);
                end
            end
            ST_DECIDE: begin
                if (r_n < r_lim) begin
                    r_act  <= ACT_INSERT;
                    r_slot <= r_pos;
                    r_idx  <= r_n;
                    r_n    <= r_n + LIM_W'(1);
                end else if (r_pos >= r_n) begin
                    r_act  <= ACT_DROP;
                    r_slot <= r_lim;
                end else begin
                    r_act  <= ACT_EVICT;
                    r_slot <= r_pos;
                end
            end
            ST_EV_LAT: begin
                r_ev  <= i_rd_time;
                r_idx <= w_last;
            end
            ST_SH_WR: begin
                r_idx <= w_idx_dec;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // result word
    assign o_res.action       = r_act;
    assign o_res.slot         = r_slot[OUT_W-1:0];
    assign o_res.fill_count   = r_n[OUT_W-1:0];
    assign o_res.evicted_time = r_ev;

endmodule

/* rtl/stw_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stw_chk
// Port-level checks of the sorted timestamp window, bound to the top level.
// ----------------------------------------------------------------------------
module stw_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic [stw_pkg::TIME_W-1:0] i_record_time,
    input logic [stw_pkg::PAY_W-1:0]  i_record_payload,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [1:0]                 o_action,
    input logic [stw_pkg::OUT_W-1:0]  o_slot,
    input logic [stw_pkg::OUT_W-1:0]  o_fill_count,
    input logic [stw_pkg::TIME_W-1:0] o_evicted_time,
    input logic                       i_cfg_we,
    input logic [stw_pkg::CFG_W-1:0]  i_cfg_data
);

    import stw_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_action) && $stable(o_slot)
            && $stable(o_fill_count) && $stable(o_evicted_time))
        else $error("result word changed while stalled");

    // taking a word starts the sequence and drops ready
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after a word was taken");

    // only an eviction reports an evicted timestamp
    a_ev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_action != ACT_EVICT) |-> o_evicted_time == '0)
        else $error("evicted time set without eviction");

    // a kept record sits inside the window
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_action != ACT_DROP) |-> (o_fill_count != '0) && (o_slot < o_fill_count))
        else $error("slot outside the held records");

endmodule

bind sorted_timestamp_window stw_chk u_chk (.*);
